### rtl/pcx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared types, codes and helper functions of the PCX plane run-length encoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

	localparam logic [7:0] MARK_BASE = 8'hC0;
	localparam logic [7:0] ESCAPE    = 8'hC1;
	localparam logic [7:0] MARK_FULL = 8'hFF;
	localparam logic [5:0] RUN_LAST  = 6'd62;

	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_BPP   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_RED   = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_GREEN = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_BLUE  = 2'd3;

	localparam logic [2:0] BPP_ONE   = 3'd1;
	localparam logic [2:0] BPP_TWO   = 3'd2;
	localparam logic [2:0] BPP_THREE = 3'd3;
	localparam logic [2:0] BPP_FOUR  = 3'd4;

	localparam logic [1:0] PLANE_RED   = 2'd0;
	localparam logic [1:0] PLANE_GREEN = 2'd1;

	localparam logic [15:0] RED_MASK_RST   = 16'hF800;
	localparam logic [15:0] GREEN_MASK_RST = 16'h07E0;
	localparam logic [15:0] BLUE_MASK_RST  = 16'h001F;

	// extracted channel value on its way to the run encoder
	typedef struct packed {
		logic [7:0] value;
		logic       seg_end;
	} chan_t;

	// all bytes caused by one pixel, first byte in bytes[0]
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		logic            seg_end;
	} entry_t;

	typedef struct packed {
		logic [1:0] n;
		logic [7:0] b0;
		logic [7:0] b1;
	} flush_t;

	// bytes sent for a pending run
	function automatic flush_t flush_run(input logic [7:0] value, input logic [5:0] len);
		flush_t f;
		f.n  = 2'd2;
		f.b0 = MARK_BASE + {2'b00, len};
		f.b1 = value;
		if (len == 6'd0) begin
			f.n = 2'd0;
		end else if (len == 6'd1) begin
			if (value >= MARK_BASE) begin
				f.b0 = ESCAPE;
			end else begin
				f.n  = 2'd1;
				f.b0 = value;
			end
		end
		return f;
	endfunction

	// rotate amount (top mask bit - 7) mod 32, empty mask counts as bit -1
	function automatic logic [4:0] rot_amount(input logic [15:0] mask);
		logic [4:0] r;
		r = 5'd24;
		for (int b = 0; b < 16; b++) begin
			if (mask[b]) begin
				r = 5'(b + 25);
			end
		end
		return r;
	endfunction

endpackage

### rtl/pcx_rle_plane_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_rle_plane_encoder
// PCX run-length encoder for one 8-bit channel extracted from raw pixels.
// ----------------------------------------------------------------------------
// The front end takes one pixel per cycle while the queue is not full: it
// extracts the channel into a register and then updates the run state,
// writing all bytes caused by that pixel (up to four) as one group into a
// queue of FIFO_DEPTH groups. The back end sends one byte per cycle from the
// queue through an output register while out_ready does not stall it, so the
// pixel rate follows the bytes each pixel produces, two per pixel for
// alternating escaped values. Bytes pass the extraction register, queue
// and output register. Configuration takes effect on the next pixel.
// ----------------------------------------------------------------------------
module pcx_rle_plane_encoder #(
	parameter int unsigned FIFO_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [pcx_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [pcx_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [31:0]                    pixel_raw,
	input  logic [1:0]                     plane,
	input  logic                           segment_end,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     out_byte,
	output logic                           item_last,
	output logic                           segment_done
);

	logic            chan_valid;
	logic            chan_take;
	pcx_pkg::chan_t  chan;
	logic            fifo_full;
	logic            fifo_empty;
	logic            push;
	logic            pop;
	pcx_pkg::entry_t entry;
	pcx_pkg::entry_t head;

	pcx_extract u_extract (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_raw   (pixel_raw),
		.plane       (plane),
		.segment_end (segment_end),
		.chan_valid  (chan_valid),
		.chan_take   (chan_take),
		.chan        (chan)
	);

	pcx_classify u_classify (
		.clk        (clk),
		.arst_n     (arst_n),
		.chan_valid (chan_valid),
		.chan_take  (chan_take),
		.chan       (chan),
		.fifo_full  (fifo_full),
		.push       (push),
		.entry      (entry)
	);

	pcx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (entry),
		.pop       (pop),
		.head      (head),
		.empty     (fifo_empty),
		.full      (fifo_full)
	);

	pcx_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.empty        (fifo_empty),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.item_last    (item_last),
		.segment_done (segment_done)
	);

endmodule

### rtl/pcx_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_fifo
// Small register queue of encoded byte groups between front and back end.
// ----------------------------------------------------------------------------
module pcx_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pcx_pkg::entry_t push_data,
	input  logic            pop,
	output pcx_pkg::entry_t head,
	output logic            empty,
	output logic            full
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	pcx_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == CNT_W'(DEPTH));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/pcx_extract.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_extract
// Configuration registers and channel extraction stage of the front end.
// ----------------------------------------------------------------------------
module pcx_extract (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [pcx_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [pcx_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [31:0]                        pixel_raw,
	input  logic [1:0]                         plane,
	input  logic                               segment_end,
	output logic                               chan_valid,
	input  logic                               chan_take,
	output pcx_pkg::chan_t                     chan
);

	logic [2:0]     bpp_q;
	logic [15:0]    red_mask_q;
	logic [15:0]    green_mask_q;
	logic [15:0]    blue_mask_q;
	logic [4:0]     red_rot_q;
	logic [4:0]     green_rot_q;
	logic [4:0]     blue_rot_q;
	logic           valid_s1;
	pcx_pkg::chan_t chan_s1;
	logic [15:0]    sel_mask;
	logic [4:0]     sel_rot;
	logic [31:0]    masked;
	logic [63:0]    rotated;
	logic [7:0]     wide_byte;
	logic [7:0]     value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q        <= pcx_pkg::BPP_FOUR;
			red_mask_q   <= pcx_pkg::RED_MASK_RST;
			green_mask_q <= pcx_pkg::GREEN_MASK_RST;
			blue_mask_q  <= pcx_pkg::BLUE_MASK_RST;
			red_rot_q    <= pcx_pkg::rot_amount(pcx_pkg::RED_MASK_RST);
			green_rot_q  <= pcx_pkg::rot_amount(pcx_pkg::GREEN_MASK_RST);
			blue_rot_q   <= pcx_pkg::rot_amount(pcx_pkg::BLUE_MASK_RST);
		end else if (cfg_write) begin
			unique case (cfg_addr)
				pcx_pkg::REG_BPP: begin
					bpp_q <= cfg_wdata[2:0];
				end
				pcx_pkg::REG_RED: begin
					red_mask_q <= cfg_wdata;
					red_rot_q  <= pcx_pkg::rot_amount(cfg_wdata);
				end
				pcx_pkg::REG_GREEN: begin
					green_mask_q <= cfg_wdata;
					green_rot_q  <= pcx_pkg::rot_amount(cfg_wdata);
				end
				pcx_pkg::REG_BLUE: begin
					blue_mask_q <= cfg_wdata;
					blue_rot_q  <= pcx_pkg::rot_amount(cfg_wdata);
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (plane)
			pcx_pkg::PLANE_RED: begin
				sel_mask  = red_mask_q;
				sel_rot   = red_rot_q;
				wide_byte = pixel_raw[23:16];
			end
			pcx_pkg::PLANE_GREEN: begin
				sel_mask  = green_mask_q;
				sel_rot   = green_rot_q;
				wide_byte = pixel_raw[15:8];
			end
			default: begin
				sel_mask  = blue_mask_q;
				sel_rot   = blue_rot_q;
				wide_byte = pixel_raw[7:0];
			end
		endcase
		masked  = {16'h0000, pixel_raw[15:0] & sel_mask};
		rotated = {masked, masked} >> sel_rot;
		unique case (bpp_q) inside
			pcx_pkg::BPP_ONE:                     value = pixel_raw[7:0];
			pcx_pkg::BPP_TWO:                     value = rotated[7:0];
			pcx_pkg::BPP_THREE, pcx_pkg::BPP_FOUR: value = wide_byte;
			default:                              value = 8'h00;
		endcase
	end

	assign in_ready   = !valid_s1 || chan_take;
	assign chan_valid = valid_s1;
	assign chan       = chan_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			chan_s1.value   <= value;
			chan_s1.seg_end <= segment_end;
		end
	end

endmodule

### rtl/pcx_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_classify
// Run tracking: turns each channel value into the group of bytes it causes.
// ----------------------------------------------------------------------------
module pcx_classify (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            chan_valid,
	output logic            chan_take,
	input  pcx_pkg::chan_t  chan,
	input  logic            fifo_full,
	output logic            push,
	output pcx_pkg::entry_t entry
);

	logic [7:0]       run_value_q;
	logic [5:0]       run_length_q;
	logic             in_segment_q;
	logic [7:0]       next_value;
	logic [5:0]       next_length;
	pcx_pkg::flush_t  first;
	pcx_pkg::flush_t  second;
	logic [1:0]       second_n;
	logic [2:0]       total;

	assign chan_take = chan_valid && !fifo_full;

	always_comb begin
		first       = '0;
		next_value  = chan.value;
		next_length = 6'd1;
		if (!in_segment_q) begin
			first = '0;
		end else if (chan.value == run_value_q) begin
			next_value  = run_value_q;
			next_length = run_length_q + 1'b1;
			if (run_length_q == pcx_pkg::RUN_LAST) begin
				first.n     = 2'd2;
				first.b0    = pcx_pkg::MARK_FULL;
				first.b1    = run_value_q;
				next_length = 6'd0;
			end
		end else begin
			first = pcx_pkg::flush_run(run_value_q, run_length_q);
		end
		second   = pcx_pkg::flush_run(next_value, next_length);
		second_n = chan.seg_end ? second.n : 2'd0;
		total    = {1'b0, first.n} + {1'b0, second_n};

		entry.bytes = '0;
		case (first.n)
			2'd0: begin
				entry.bytes[0] = second.b0;
				entry.bytes[1] = second.b1;
			end
			2'd1: begin
				entry.bytes[0] = first.b0;
				entry.bytes[1] = second.b0;
				entry.bytes[2] = second.b1;
			end
			default: begin
				entry.bytes[0] = first.b0;
				entry.bytes[1] = first.b1;
				entry.bytes[2] = second.b0;
				entry.bytes[3] = second.b1;
			end
		endcase
		entry.last_idx = 2'(total - 3'd1);
		entry.seg_end  = chan.seg_end;
	end

	assign push = chan_take && (total != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q  <= 8'h00;
			run_length_q <= 6'd0;
			in_segment_q <= 1'b0;
		end else if (chan_take) begin
			run_value_q  <= next_value;
			run_length_q <= chan.seg_end ? 6'd0 : next_length;
			in_segment_q <= !chan.seg_end;
		end
	end

endmodule

### rtl/pcx_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcx_emit
// Back end: sends the queued byte groups one byte per cycle, while out_ready
// does not stall it, through an output register.
// ----------------------------------------------------------------------------
module pcx_emit (
	input  logic            clk,
	input  logic            arst_n,
	input  pcx_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            item_last,
	output logic            segment_done
);

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       done_q;
	logic       load;
	logic       is_last;

	assign load    = !empty && (!valid_q || out_ready);
	assign is_last = (idx_q == head.last_idx);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= head.bytes[idx_q];
			last_q <= is_last;
			done_q <= is_last && head.seg_end;
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign item_last    = last_q;
	assign segment_done = done_q;

endmodule
